// ===== hw/rtl/dominant_line_vote_macros.svh =====
// ---------------------------------------------------------------------------
// dominant_line_vote assertion macros
// Shorthand for clocked assertions with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef DOMINANT_LINE_VOTE_MACROS_SVH
`define DOMINANT_LINE_VOTE_MACROS_SVH

// Same-cycle implication.
`define DLV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dominant_line_vote: same-cycle check failed");

// Next-cycle implication.
`define DLV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dominant_line_vote: next-cycle check failed");

`endif

// ===== hw/rtl/dlv_pkg.sv =====
// ---------------------------------------------------------------------------
// dlv_pkg
// Item types, history cell types and fixed widths of the line vote block.
// ---------------------------------------------------------------------------
package dlv_pkg;

    localparam int RESP_W    = 24;
    localparam int LINE_W    = 4;
    localparam int OCC_W     = 5;
    localparam int RATIO_W   = 17;
    localparam int FRAC_BITS = 16;

    localparam logic [RESP_W-1:0]  THR_RESET = 24'd5000;
    localparam logic [OCC_W-1:0]   OCC_MAX   = 5'd31;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 17'd65536;

    typedef struct packed {
        logic [RESP_W-1:0] response;
        logic              last_in_frame;
    } in_item_t;

    typedef struct packed {
        logic [LINE_W-1:0]  dominant_line;
        logic               dominant_valid;
        logic [OCC_W-1:0]   occurrences;
        logic [RATIO_W-1:0] ratio_q16;
        logic [RESP_W-1:0]  frame_max;
        logic [LINE_W-1:0]  frame_max_line;
    } out_item_t;

    // One history slot; valid low is the empty marker.
    typedef struct packed {
        logic              valid;
        logic [LINE_W-1:0] line;
    } hist_t;

    // Vote probe travelling down the cell row.
    typedef struct packed {
        logic              live;
        logic              none;
        logic [LINE_W-1:0] line;
    } probe_t;

endpackage

// ===== hw/rtl/dlv_cell.sv =====
// ---------------------------------------------------------------------------
// dlv_cell
// One history slot plus one stage of the systolic vote counter.
// ---------------------------------------------------------------------------
module dlv_cell
    import dlv_pkg::*;
#(
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  hist_t            hist_in,
    output hist_t            hist_out,
    input  probe_t           probe_in,
    input  logic [CNT_W-1:0] cnt_in,
    output probe_t           probe_out,
    output logic [CNT_W-1:0] cnt_out
);

    hist_t            hist_reg,  hist_next;
    probe_t           probe_reg, probe_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             match;

    always_comb
    begin
        if (probe_in.none)
        begin
            match = !hist_reg.valid;
        end
        else
        begin
            match = hist_reg.valid && (hist_reg.line == probe_in.line);
        end
        hist_next  = shift_en ? hist_in : hist_reg;
        probe_next = probe_in;
        cnt_next   = cnt_in + CNT_W'(match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            probe_reg <= '0;
        end
        else
        begin
            hist_reg  <= hist_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    assign hist_out  = hist_reg;
    assign probe_out = probe_reg;
    assign cnt_out   = cnt_reg;

endmodule

// ===== hw/rtl/dlv_divider.sv =====
// ---------------------------------------------------------------------------
// dlv_divider
// Restoring divider, one quotient bit per cycle: (dividend << 16) / divisor
// for dividend <= divisor.
// ---------------------------------------------------------------------------
module dlv_divider
    import dlv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RESP_W-1:0]  dividend,
    input  logic [RESP_W-1:0]  divisor,
    output logic               done,
    output logic [RATIO_W-1:0] quotient
);

    localparam int STEP_W = $clog2(RATIO_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RATIO_W - 1);

    logic [RESP_W:0]    rem_reg,  rem_next;
    logic [RESP_W-1:0]  div_reg,  div_next;
    logic [RATIO_W-1:0] quo_reg,  quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [RESP_W:0]    trial;
    logic               ge;

    always_comb
    begin
        // first step tests the integer bit, later steps shift in a zero
        trial = (step_reg == '0) ? rem_reg : {rem_reg[RESP_W-1:0], 1'b0};
        ge    = (trial >= {1'b0, div_reg});

        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = {1'b0, dividend};
            div_next  = divisor;
            quo_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (trial - {1'b0, div_reg}) : trial;
            quo_next  = {quo_reg[RATIO_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/dominant_line_vote.sv =====
// ---------------------------------------------------------------------------
// dominant_line_vote
// Per-frame strongest line with a sliding-window majority vote over frames.
// ---------------------------------------------------------------------------
// Line responses of a frame arrive one item each. The closing item starts
// the frame-end sequence, during which in_stall is high: the winner is
// pushed into the history row if the frame maximum exceeds the threshold,
// MAX_LINES + 1 vote probes travel the row of history cells, a decision
// state follows, and, when a ratio is due, the 17-step ratio divider runs.
// The frame-end time is set by the cell row length, the divider and any
// result still waiting in the output register. The result sits in an
// output register, so the next frame is accepted while it waits; a second
// result waits until the first is taken.
// ---------------------------------------------------------------------------
`include "dominant_line_vote_macros.svh"

module dominant_line_vote
    import dlv_pkg::*;
#(
    parameter int MAX_LINES     = 16,
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    // threshold register
    input  logic              cfg_wr_en,
    input  logic [RESP_W-1:0] cfg_wr_data,
    // line responses
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    // frame results
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item
);

    localparam int LC_W  = $clog2(MAX_LINES + 1);
    localparam int IDX_W = $clog2(MAX_LINES);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PUSH   = 3'd1;
    localparam logic [2:0] ST_VOTE   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    // control state
    logic [2:0]        state_reg,  state_next;
    logic [RESP_W-1:0] thr_reg,    thr_next;
    logic [LC_W-1:0]   lc_reg,     lc_next;
    logic [RESP_W-1:0] max_reg,    max_next;
    logic [LINE_W-1:0] mline_reg,  mline_next;
    logic [LC_W-1:0]   inj_reg,    inj_next;
    logic              inj_on_reg, inj_on_next;
    logic [CNT_W-1:0]  best_cnt_reg,   best_cnt_next;
    logic [LINE_W-1:0] best_line_reg,  best_line_next;
    logic              best_valid_reg, best_valid_next;
    logic              out_valid_reg,  out_valid_next;

    // payload
    logic [RESP_W-1:0]  resp_mem [MAX_LINES];
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    out_item_t          out_item_reg, out_item_next;

    logic               in_acc;
    logic               stored;
    logic               push_en;
    logic               out_load;
    logic               div_start;
    logic               div_done;
    logic [RATIO_W-1:0] div_quo;
    logic               ratio_ok;

    hist_t              hist_w  [HISTORY_DEPTH + 1];
    probe_t             probe_w [HISTORY_DEPTH + 1];
    logic [CNT_W-1:0]   cnt_w   [HISTORY_DEPTH + 1];
    probe_t             tail;
    logic [CNT_W-1:0]   tail_cnt;

    assign in_acc  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign stored  = (lc_reg < LC_W'(MAX_LINES));
    assign push_en = (state_reg == ST_PUSH) && (max_reg > thr_reg);

    // new history entry enters at the head of the cell row
    assign hist_w[0] = '{valid: 1'b1, line: mline_reg};

    // probes: lines from the highest down, then the empty marker
    always_comb
    begin
        probe_w[0].live = (state_reg == ST_VOTE) && inj_on_reg;
        probe_w[0].none = (inj_reg == '0);
        probe_w[0].line = LINE_W'(inj_reg - LC_W'(1));
        cnt_w[0]        = '0;
    end

    genvar k;
    generate
        for (k = 0; k < HISTORY_DEPTH; k++)
        begin : g_cell
            dlv_cell #(
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (push_en),
                .hist_in   (hist_w[k]),
                .hist_out  (hist_w[k + 1]),
                .probe_in  (probe_w[k]),
                .cnt_in    (cnt_w[k]),
                .probe_out (probe_w[k + 1]),
                .cnt_out   (cnt_w[k + 1])
            );
        end
    endgenerate

    assign tail     = probe_w[HISTORY_DEPTH];
    assign tail_cnt = cnt_w[HISTORY_DEPTH];

    // winner's response is only meaningful if that line arrived this frame
    assign ratio_ok  = best_valid_reg && (max_reg != '0) &&
                       (32'(best_line_reg) < 32'(lc_reg));
    assign div_start = (state_reg == ST_DECIDE) && ratio_ok;

    dlv_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (resp_mem[best_line_reg[IDX_W-1:0]]),
        .divisor  (max_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        thr_next        = cfg_wr_en ? cfg_wr_data : thr_reg;
        lc_next         = lc_reg;
        max_next        = max_reg;
        mline_next      = mline_reg;
        inj_next        = inj_reg;
        inj_on_next     = inj_on_reg;
        best_cnt_next   = best_cnt_reg;
        best_line_next  = best_line_reg;
        best_valid_next = best_valid_reg;
        ratio_next      = ratio_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // items past the line capacity only matter for the frame mark
                    if (stored)
                    begin
                        if (in_item.response > max_reg)
                        begin
                            max_next   = in_item.response;
                            mline_next = LINE_W'(lc_reg);
                        end
                        lc_next = lc_reg + LC_W'(1);
                    end
                    if (in_item.last_in_frame)
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                inj_next        = LC_W'(MAX_LINES);
                inj_on_next     = 1'b1;
                best_cnt_next   = '0;
                best_line_next  = '0;
                best_valid_next = 1'b0;
                state_next      = ST_VOTE;
            end
            ST_VOTE:
            begin
                if (inj_on_reg)
                begin
                    if (inj_reg == '0)
                    begin
                        inj_on_next = 1'b0;
                    end
                    else
                    begin
                        inj_next = inj_reg - LC_W'(1);
                    end
                end
                // strict compare: higher lines come first and keep ties,
                // the empty marker comes last and loses ties
                if (tail.live)
                begin
                    if (tail_cnt > best_cnt_reg)
                    begin
                        best_cnt_next   = tail_cnt;
                        best_line_next  = tail.none ? '0 : tail.line;
                        best_valid_next = !tail.none;
                    end
                    if (tail.none)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                ratio_next = '0;
                state_next = ratio_ok ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ratio_next = div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_item_next.dominant_line  = best_line_reg;
                    out_item_next.dominant_valid = best_valid_reg;
                    out_item_next.occurrences    = (32'(best_cnt_reg) > 32'(OCC_MAX)) ?
                                                   OCC_MAX : OCC_W'(best_cnt_reg);
                    out_item_next.ratio_q16      = ratio_reg;
                    out_item_next.frame_max      = max_reg;
                    out_item_next.frame_max_line = mline_reg;
                    out_valid_next = 1'b1;
                    lc_next        = '0;
                    max_next       = '0;
                    mline_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            lc_reg         <= '0;
            max_reg        <= '0;
            mline_reg      <= '0;
            inj_reg        <= '0;
            inj_on_reg     <= 1'b0;
            best_cnt_reg   <= '0;
            best_line_reg  <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            lc_reg         <= lc_next;
            max_reg        <= max_next;
            mline_reg      <= mline_next;
            inj_reg        <= inj_next;
            inj_on_reg     <= inj_on_next;
            best_cnt_reg   <= best_cnt_next;
            best_line_reg  <= best_line_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ratio_reg    <= ratio_next;
        out_item_reg <= out_item_next;
        if (in_acc && stored)
        begin
            resp_mem[lc_reg[IDX_W-1:0]] <= in_item.response;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // divider runs only for a real winner against a nonzero maximum
    `DLV_ASSERT_IMPL(a_div_start_ok, clk, rst_n, div_start, best_valid_reg && (max_reg != '0))
    // the empty marker winning gives no line and no ratio
    `DLV_ASSERT_IMPL(a_none_quiet, clk, rst_n, out_valid_reg && !out_item_reg.dominant_valid, (out_item_reg.ratio_q16 == '0) && (out_item_reg.dominant_line == '0))
    `DLV_ASSERT_IMPL(a_ratio_range, clk, rst_n, out_valid_reg, out_item_reg.ratio_q16 <= RATIO_MAX)
    // frame state is cleared when the result is loaded
    `DLV_ASSERT_NEXT(a_frame_cleared, clk, rst_n, out_load, (lc_reg == '0) && (max_reg == '0) && out_valid_reg && (state_reg == ST_IDLE))

endmodule
